// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BFR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define BFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BFR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/bfr_pkg.sv =====
package bfr_pkg;

  localparam int PIX_W      = 32;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int THR_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_WIDTH  = 32;

  localparam logic [FW_W-1:0]   DEF_FRAME_WIDTH  = 12'd640;
  localparam logic [FH_W-1:0]   DEF_FRAME_HEIGHT = 16'd480;
  localparam logic [THR_W-1:0]  DEF_THRESHOLD    = 24'd8355840;
  localparam logic [GAIN_W-1:0] DEF_GAIN         = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 4'd3;

  // 0.333 and 0.0004 in Q0.16.
  localparam logic [14:0] AVG_MUL    = 15'd21823;
  localparam logic [4:0]  DITHER_MUL = 5'd26;

  typedef enum logic [1:0] {
    LOAD_NONE,
    LOAD_MAIN,
    LOAD_EDGE,
    LOAD_LAST
  } bfr_load_t;

  typedef struct packed {
    logic      clear_step;
    logic      take;
    logic      rd_hi;
    logic      keep_main;
    logic      update;
    logic      wr_hi;
    bfr_load_t load;
    logic      last;
  } bfr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic emit_main;
    logic emit_edge;
    logic emit_last;
  } bfr_status_t;

endpackage

// ===== design/bfr_if.sv =====
interface bfr_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bfr_pkg::PIX_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

interface bfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [bfr_pkg::PIX_W-1:0] out_pixel;
  logic [bfr_pkg::COL_W-1:0] out_column;
  logic [bfr_pkg::ROW_W-1:0] out_row;
  logic                       last_of_run;

  modport source (output valid, output out_pixel, output out_column, output out_row,
                  output last_of_run, input ready);
  modport sink (input valid, input out_pixel, input out_column, input out_row,
                input last_of_run, output ready);
endinterface

interface bfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfr_pkg::CFG_IDX_W-1:0]  index;
  logic [bfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bfr_ctrl.sv =====
`include "assert_macros.svh"

module bfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfr_pkg::bfr_status_t status,
  output bfr_pkg::bfr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_EMIT_MAIN,
    S_EMIT_EDGE,
    S_EMIT_LAST
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = bfr_pkg::LOAD_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = in_valid && in_ready;
        if (cmd.take) begin
          state_next = S_RD_LO;
        end
      end
      S_RD_LO: begin
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi     = 1'b1;
        cmd.keep_main = 1'b1;
        state_next    = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.update = 1'b1;
        state_next = S_WR_HI;
      end
      S_WR_HI: begin
        cmd.wr_hi = 1'b1;
        priority if (status.emit_main) begin
          state_next = S_EMIT_MAIN;
        end else if (status.emit_edge) begin
          state_next = S_EMIT_EDGE;
        end else if (status.emit_last) begin
          state_next = S_EMIT_LAST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_MAIN: begin
        if (status.out_free) begin
          cmd.load = bfr_pkg::LOAD_MAIN;
          cmd.last = !status.emit_edge && !status.emit_last;
          priority if (status.emit_edge) begin
            state_next = S_EMIT_EDGE;
          end else if (status.emit_last) begin
            state_next = S_EMIT_LAST;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_EDGE: begin
        if (status.out_free) begin
          cmd.load   = bfr_pkg::LOAD_EDGE;
          cmd.last   = !status.emit_last;
          state_next = status.emit_last ? S_EMIT_LAST : S_IDLE;
        end
      end
      S_EMIT_LAST: begin
        if (status.out_free) begin
          cmd.load   = bfr_pkg::LOAD_LAST;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  `BFR_ASSERT_IMPLY(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `BFR_ASSERT_NEXT(a_take_seq, clk, rst, in_valid && in_ready, state == S_RD_LO)

endmodule

// ===== design/bfr_datapath.sv =====
`include "assert_macros.svh"

module bfr_datapath #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bfr_pkg::bfr_cmd_t          cmd,
  output bfr_pkg::bfr_status_t       status,
  bfr_cfg_if.sink                    cfg,
  input  logic [bfr_pkg::PIX_W-1:0] pixel_word,
  bfr_out_if.source                  pix_out
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = (CW + 1 > bfr_pkg::FW_W) ? CW + 1 : bfr_pkg::FW_W;

  logic [bfr_pkg::FW_W-1:0]   frame_width;
  logic [bfr_pkg::FH_W-1:0]   frame_height;
  logic [bfr_pkg::THR_W-1:0]  threshold_level;
  logic [bfr_pkg::GAIN_W-1:0] intensity_gain;

  logic [7:0]                 green_back_one;
  logic [7:0]                 green_back_two;
  logic [bfr_pkg::PIX_W-1:0] pixel_back_one;
  logic [CW-1:0]              column_count;
  logic [bfr_pkg::ROW_W-1:0] row_count;
  logic [CW-1:0]              clr_addr;
  logic                       clr_run;

  logic [bfr_pkg::PIX_W-1:0] px_q;
  logic [bfr_pkg::PIX_W-1:0] pb1_q;
  logic [CW-1:0]              c_q;
  logic [bfr_pkg::ROW_W-1:0] r_q;
  logic [9:0]                 sum_q;
  logic [24:0]                thr_q;
  logic                       have_v;
  logic                       col_ok;
  logic                       last_col_q;
  logic                       add_ok;
  logic                       emit_main;
  logic                       emit_edge;
  logic                       emit_last;

  logic [23:0] avg_q;
  logic        gt_q;
  logic [39:0] prod_q;
  logic [13:0] vsum_q;
  logic [28:0] vprod_q;

  logic [bfr_pkg::PIX_W-1:0] prev_mem [MAX_WIDTH];
  logic [23:0]                bloom_mem [MAX_WIDTH];
  logic [bfr_pkg::PIX_W-1:0] prev_q;
  logic [23:0]                bloom_q;
  logic [bfr_pkg::PIX_W-1:0] p0;
  logic [bfr_pkg::PIX_W-1:0] p1;

  logic                       out_valid;
  logic [bfr_pkg::PIX_W-1:0] out_pixel;
  logic [bfr_pkg::COL_W-1:0] out_column;
  logic [bfr_pkg::ROW_W-1:0] out_row;
  logic                       out_last;

  logic [7:0]                 g;
  logic [WB-1:0]              fw;
  logic [WB-1:0]              w_eff;
  logic [bfr_pkg::FH_W-1:0]  h_eff;
  logic                       last_col_d;
  logic                       last_row_d;
  logic [CW-1:0]              x_d;
  logic [7:0]                 key;
  logic [12:0]                dither;
  logic [CW-1:0]              xm1;
  logic [39:0]                prod_rnd;
  logic [11:0]                cur;
  logic [29:0]                vrnd;
  logic [13:0]                vb;
  logic [7:0]                 vb8;
  logic [CW-1:0]              prev_ra;
  logic                       prev_we;
  logic [CW-1:0]              prev_wa;
  logic [bfr_pkg::PIX_W-1:0] prev_wd;
  logic [CW-1:0]              bloom_a;
  logic                       bloom_we;
  logic [23:0]                bloom_wd;

  function automatic logic [31:0] add_bloom(input logic [31:0] p, input logic [7:0] v);
    logic [8:0]  s;
    logic [31:0] res;
    res = {p[31:24], 24'd0};
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, p[8*i +: 8]} + {1'b0, v};
      res[8*i +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return res;
  endfunction

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= bfr_pkg::DEF_FRAME_WIDTH;
      frame_height    <= bfr_pkg::DEF_FRAME_HEIGHT;
      threshold_level <= bfr_pkg::DEF_THRESHOLD;
      intensity_gain  <= bfr_pkg::DEF_GAIN;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bfr_pkg::CFG_FRAME_WIDTH:  frame_width     <= cfg.data[bfr_pkg::FW_W-1:0];
        bfr_pkg::CFG_FRAME_HEIGHT: frame_height    <= cfg.data[bfr_pkg::FH_W-1:0];
        bfr_pkg::CFG_THRESHOLD:    threshold_level <= cfg.data[bfr_pkg::THR_W-1:0];
        bfr_pkg::CFG_GAIN:         intensity_gain  <= cfg.data[bfr_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    g  = pixel_word[15:8];
    fw = WB'(frame_width);
    priority if (fw < WB'(bfr_pkg::MIN_WIDTH)) begin
      w_eff = WB'(bfr_pkg::MIN_WIDTH);
    end else if (fw > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = fw;
    end
    h_eff      = (frame_height == '0) ? 16'd1 : frame_height;
    last_col_d = (WB'(column_count) + WB'(1)) >= w_eff;
    last_row_d = ({1'b0, row_count} + 17'd1) >= {1'b0, h_eff};
    x_d        = column_count - CW'(1);
    key        = 8'(x_d) ^ row_count[7:0];
    dither     = {5'd0, key} * 13'(bfr_pkg::DITHER_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      green_back_one <= '0;
      green_back_two <= '0;
      column_count   <= '0;
      row_count      <= '0;
      have_v         <= 1'b0;
      col_ok         <= 1'b0;
      last_col_q     <= 1'b0;
      add_ok         <= 1'b0;
      emit_main      <= 1'b0;
      emit_edge      <= 1'b0;
      emit_last      <= 1'b0;
    end else if (cmd.take) begin
      green_back_two <= green_back_one;
      green_back_one <= g;
      have_v         <= column_count >= CW'(2);
      col_ok         <= column_count != '0;
      last_col_q     <= last_col_d;
      add_ok         <= (column_count >= CW'(2)) && (row_count >= 16'd2) && (row_count < h_eff);
      emit_main      <= (row_count != '0) && (column_count != '0);
      emit_edge      <= (row_count != '0) && last_col_d;
      emit_last      <= last_row_d;
      if (last_col_d) begin
        column_count <= '0;
        row_count    <= last_row_d ? '0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_q           <= pixel_word;
      pb1_q          <= pixel_back_one;
      pixel_back_one <= pixel_word;
      c_q            <= column_count;
      r_q            <= row_count;
      sum_q          <= 10'(green_back_two) + 10'(green_back_one) + 10'(g);
      thr_q          <= {1'b0, threshold_level} + 25'(dither);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    avg_q   <= {14'd0, sum_q} * 24'(bfr_pkg::AVG_MUL);
    gt_q    <= {1'b0, avg_q} > thr_q;
    prod_q  <= {16'd0, avg_q} * {24'd0, intensity_gain};
    vprod_q <= {15'd0, vsum_q} * 29'(bfr_pkg::AVG_MUL);
    if (cmd.keep_main) begin
      p0 <= prev_q;
    end
    if (cmd.update) begin
      p1     <= prev_q;
      vsum_q <= 14'(bloom_q[23:12]) + 14'(bloom_q[11:0]) + 14'(cur);
    end
  end

  always_comb begin
    xm1      = c_q - CW'(1);
    prod_rnd = prod_q + (40'd1 << 27);
    cur      = gt_q ? prod_rnd[39:28] : 12'd0;
    vrnd     = 30'(vprod_q) + 30'd32768;
    vb       = vrnd[29:16];
    vb8      = (vb > 14'd255) ? 8'hFF : vb[7:0];

    prev_ra  = cmd.rd_hi ? c_q : xm1;
    prev_we  = (cmd.update && col_ok) || (cmd.wr_hi && last_col_q);
    prev_wa  = cmd.wr_hi ? c_q : xm1;
    prev_wd  = cmd.wr_hi ? px_q : pb1_q;

    bloom_a  = cmd.clear_step ? clr_addr : xm1;
    bloom_we = cmd.clear_step || (cmd.update && have_v);
    bloom_wd = cmd.clear_step ? 24'd0 : {bloom_q[11:0], cur};
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (bloom_we) begin
      bloom_mem[bloom_a] <= bloom_wd;
    end
    bloom_q <= bloom_mem[bloom_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load != bfr_pkg::LOAD_NONE) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.load)
      bfr_pkg::LOAD_MAIN: begin
        out_pixel  <= add_ok ? add_bloom(p0, vb8) : p0;
        out_column <= bfr_pkg::COL_W'(xm1);
        out_row    <= r_q - 16'd1;
        out_last   <= cmd.last;
      end
      bfr_pkg::LOAD_EDGE: begin
        out_pixel  <= p1;
        out_column <= bfr_pkg::COL_W'(c_q);
        out_row    <= r_q - 16'd1;
        out_last   <= cmd.last;
      end
      bfr_pkg::LOAD_LAST: begin
        out_pixel  <= px_q;
        out_column <= bfr_pkg::COL_W'(c_q);
        out_row    <= r_q;
        out_last   <= cmd.last;
      end
      bfr_pkg::LOAD_NONE: begin
      end
    endcase
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.out_pixel   = out_pixel;
  assign pix_out.out_column  = out_column;
  assign pix_out.out_row     = out_row;
  assign pix_out.last_of_run = out_last;

  assign status.clear_last = (clr_addr == CW'(MAX_WIDTH - 1));
  assign status.out_free   = !out_valid || pix_out.ready;
  assign status.emit_main  = emit_main;
  assign status.emit_edge  = emit_edge;
  assign status.emit_last  = emit_last;

  assign clr_run = cmd.clear_step && !status.clear_last;

  `BFR_ASSERT_NEXT(a_clr_adv, clk, rst, clr_run, clr_addr == $past(clr_addr + CW'(1)))
  `BFR_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.load != bfr_pkg::LOAD_NONE, status.out_free)

endmodule

// ===== design/bloom_filter_rgba8_top.sv =====
// Each accepted request passes through the states S_RD_LO, S_RD_HI, S_WR_LO and S_WR_HI,
// then through one emit state for each of its n results (0 to 3), each of which waits
// for a free output register; no new request is accepted until it is back in S_IDLE.
// Reset: synchronous, active high; the bloom line store is then swept to zero,
// a sweep during which no request is accepted (configuration writes are).
module bloom_filter_rgba8_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic      clk,
  input  logic      rst,
  bfr_cfg_if.sink   cfg,
  bfr_pix_if.sink   pixel_in,
  bfr_out_if.source pixel_out
);

  bfr_pkg::bfr_cmd_t    cmd;
  bfr_pkg::bfr_status_t status;
  logic                 in_ready;

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign pixel_in.ready = in_ready;

  bfr_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg),
    .pixel_word (pixel_in.pixel_word),
    .pix_out    (pixel_out)
  );

endmodule
